>>> src/slcd_pkg.sv
package slcd_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'hFF;
  localparam logic [7:0] SYNC_SECOND = 8'h55;

  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [15:0] IDLE_MAX      = 16'hFFFF;

  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  typedef logic [2:0] event_t;
  localparam event_t EV_NONE       = 3'd0;
  localparam event_t EV_OK         = 3'd1;
  localparam event_t EV_CHECKSUM   = 3'd2;
  localparam event_t EV_UNEXPECTED = 3'd3;
  localparam event_t EV_TIMEOUT    = 3'd4;

  typedef struct packed {
    logic [7:0]  previous_byte;
    logic        in_frame;
    logic        have_length;
    logic [7:0]  payload_length;
    logic [8:0]  byte_count;
    logic [7:0]  running_sum;
    logic [15:0] idle_count;
  } frame_state_t;

  typedef struct packed {
    event_t     event_res;
    logic [7:0] frame_length;
    logic [8:0] bytes_received;
  } result_t;

endpackage

>>> src/sync_length_checksum_deframer.sv
// Deframer for a serial byte stream. Each input word is either a received byte
// (tuser 0) or one time tick (tuser 1). The byte pair FF 55 seen outside a frame
// opens a frame: a length byte, that many payload bytes and a checksum byte
// follow, the checksum being the two's complement of the low byte of length plus
// payload. Every input word yields exactly one output word carrying an event
// (none, frame ok, checksum error, unexpected byte, timeout) and the current
// declared length and count of payload plus checksum bytes. An open frame is
// aborted when more than timeout_ticks ticks pass without a byte (65535 means
// never). The block takes one word per cycle while the output is not stalled;
// a word passes an input register and the state update into the output
// register, and backpressure on the output stalls input.
module sync_length_checksum_deframer import slcd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] frame_length, [16:8] bytes_received, zero fill
  output logic [2:0]  out_tuser,  // [2:0] event_res
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data    // timeout_ticks
);

  logic         in_valid_r;
  logic [7:0]   in_byte_r;
  logic         in_mode_r;
  logic         out_valid_r;
  result_t      res_r;
  result_t      res_nxt;
  frame_state_t st_r;
  frame_state_t st_nxt;
  logic [15:0]  timeout_r;
  logic         advance;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_valid) begin
      timeout_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_mode_r <= in_tuser;
    end
  end

  slcd_step u_step (
    .st            (st_r),
    .mode          (in_mode_r),
    .rx_byte       (in_byte_r),
    .timeout_ticks (timeout_r),
    .st_nxt        (st_nxt),
    .res           (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        st_r <= st_nxt;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.event_res;
  assign out_tdata  = {7'd0, res_r.bytes_received, res_r.frame_length};

  a_length_needs_frame: assert property (@(posedge clk) disable iff (!rst_n)
    !st_r.in_frame |-> !st_r.have_length)
    else $error("length flag set outside a frame");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.byte_count <= 9'd256)
    else $error("byte count beyond 256");

  a_frame_end_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == EV_OK || out_tuser == EV_CHECKSUM)) |->
      (out_tdata[16:8] == {1'b0, out_tdata[7:0]} + 9'd1))
    else $error("frame finished at wrong count");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready && in_valid_r) |-> !in_tready)
    else $error("input taken while both stages are full");

endmodule

>>> src/slcd_step.sv
module slcd_step import slcd_pkg::*; (
  input  frame_state_t st,
  input  logic         mode,
  input  logic [7:0]   rx_byte,
  input  logic [15:0]  timeout_ticks,
  output frame_state_t st_nxt,
  output result_t      res
);

  logic [8:0]  count_inc;
  logic [8:0]  count_last;
  logic [7:0]  expect_sum;
  logic [15:0] idle_inc;
  event_t      ev;

  assign count_inc  = st.byte_count + 9'd1;
  assign count_last = {1'b0, st.payload_length} + 9'd1;
  assign expect_sum = 8'd0 - st.running_sum;
  assign idle_inc   = (st.idle_count == IDLE_MAX) ? IDLE_MAX : st.idle_count + 16'd1;

  always_comb begin
    st_nxt = st;
    ev     = EV_NONE;
    if (mode == MODE_TICK) begin
      st_nxt.idle_count = idle_inc;
      if (st.in_frame && (idle_inc > timeout_ticks)) begin
        st_nxt.in_frame    = 1'b0;
        st_nxt.have_length = 1'b0;
        ev                 = EV_TIMEOUT;
      end
    end else begin
      st_nxt.idle_count    = '0;
      st_nxt.previous_byte = rx_byte;
      if (!st.in_frame && st.previous_byte == SYNC_FIRST && rx_byte == SYNC_SECOND) begin
        st_nxt.in_frame       = 1'b1;
        st_nxt.have_length    = 1'b0;
        st_nxt.payload_length = '0;
        st_nxt.byte_count     = '0;
        st_nxt.running_sum    = '0;
      end else if (st.in_frame) begin
        if (!st.have_length) begin
          st_nxt.payload_length = rx_byte;
          st_nxt.have_length    = 1'b1;
          st_nxt.running_sum    = rx_byte;
        end else begin
          st_nxt.byte_count = count_inc;
          // last word of the frame is the checksum
          if (count_inc == count_last) begin
            st_nxt.in_frame    = 1'b0;
            st_nxt.have_length = 1'b0;
            ev = (expect_sum == rx_byte) ? EV_OK : EV_CHECKSUM;
          end else begin
            st_nxt.running_sum = st.running_sum + rx_byte;
          end
        end
      end else if (rx_byte != SYNC_FIRST) begin
        ev = EV_UNEXPECTED;
      end
    end
  end

  assign res.event_res      = ev;
  assign res.frame_length   = st_nxt.payload_length;
  assign res.bytes_received = st_nxt.byte_count;

endmodule
